// ----- hw/rtl/u8d_pkg.sv -----
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

	localparam int CpWidth = 21;
	localparam logic [CpWidth-1:0] ReplacementChar = 21'h00FFFD;

	typedef logic [CpWidth-1:0] cp_t;
	typedef logic [1:0] pend_t;

	// one decoded result beat
	typedef struct packed {
		cp_t  code_point;
		logic replaced;
		logic run_end;
	} result_t;

	// results produced by one accepted byte
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ----- hw/rtl/u8d_byte_if.sv -----
// byte input channel
interface u8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       final_byte;

	modport source (output valid, output byte_in, output final_byte, input ready);
	modport sink (input valid, input byte_in, input final_byte, output ready);
endinterface

// ----- hw/rtl/u8d_cp_if.sv -----
// code point output channel
interface u8d_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        replaced;
	logic        run_end;

	modport source (output valid, output code_point, output replaced, output run_end,
		input ready);
	modport sink (input valid, input code_point, input replaced, input run_end,
		output ready);
endinterface

// ----- hw/rtl/u8d_decode.sv -----
// per-byte decode: next state and up to two results
module u8d_decode
	import u8d_pkg::*;
(
	input  logic [7:0] byte_in,
	input  logic       final_byte,
	input  cp_t        partial,
	input  pend_t      pending,
	output cp_t        partial_next,
	output pend_t      pending_next,
	output push_t      push
);

	logic   is_ascii, is_cont, is_lead2, is_lead3, is_lead4;
	logic   open_seq;
	logic   pre_err, main_emit, main_rep, tail_err;
	cp_t    main_cp;
	cp_t    shifted;
	pend_t  pend_dec;
	cp_t    part_body;
	pend_t  pend_body;

	// byte classes
	assign is_ascii = ~byte_in[7];
	assign is_cont  = (byte_in[7:6] == 2'b10);
	assign is_lead2 = (byte_in[7:5] == 3'b110);
	assign is_lead3 = (byte_in[7:4] == 4'b1110);
	assign is_lead4 = (byte_in[7:3] == 5'b11110);
	assign open_seq = (pending != 2'd0);

	assign shifted  = {partial[CpWidth-7:0], byte_in[5:0]};
	assign pend_dec = pending - 2'd1;

	// main byte handling
	always_comb begin
		pre_err   = 1'b0;
		main_emit = 1'b0;
		main_rep  = 1'b0;
		main_cp   = ReplacementChar;
		part_body = partial;
		pend_body = pending;
		priority if (is_ascii) begin
			pre_err   = open_seq;
			main_emit = 1'b1;
			main_cp   = {13'd0, byte_in};
			pend_body = 2'd0;
		end else if (is_cont) begin
			if (open_seq) begin
				part_body = shifted;
				pend_body = pend_dec;
				main_emit = (pend_dec == 2'd0);
				main_cp   = shifted;
			end else begin
				main_emit = 1'b1;
				main_rep  = 1'b1;
			end
		end else if (is_lead2) begin
			pre_err   = open_seq;
			pend_body = 2'd1;
			part_body = {16'd0, byte_in[4:0]};
		end else if (is_lead3) begin
			pre_err   = open_seq;
			pend_body = 2'd2;
			part_body = {17'd0, byte_in[3:0]};
		end else if (is_lead4) begin
			pre_err   = open_seq;
			pend_body = 2'd3;
			part_body = {18'd0, byte_in[2:0]};
		end else begin
			main_emit = 1'b1;
			main_rep  = 1'b1;
			pend_body = 2'd0;
		end
	end

	// end of string closes any open sequence
	assign tail_err     = final_byte && (pend_body != 2'd0);
	assign pending_next = final_byte ? 2'd0 : pend_body;
	assign partial_next = final_byte ? '0 : part_body;

	// pack results in order: replacement before, main, replacement after
	always_comb begin
		push.cnt = {1'b0, pre_err} + {1'b0, main_emit} + {1'b0, tail_err};
		push.r0.code_point = pre_err ? ReplacementChar : (main_emit ? main_cp : ReplacementChar);
		push.r0.replaced   = pre_err ? 1'b1 : (main_emit ? main_rep : 1'b1);
		push.r0.run_end    = (push.cnt == 2'd1);
		push.r1.code_point = (pre_err && main_emit) ? main_cp : ReplacementChar;
		push.r1.replaced   = (pre_err && main_emit) ? main_rep : 1'b1;
		push.r1.run_end    = 1'b1;
	end

endmodule

// ----- hw/rtl/u8d_result_queue.sv -----
// three-entry result queue, takes up to two beats per cycle
module u8d_result_queue
	import u8d_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop_ready,
	output logic    head_valid,
	output result_t head,
	output logic    space_ok
);

	localparam int Depth = 3;

	result_t     entry_q [Depth];
	result_t     entry_n [Depth];
	logic [1:0]  count_q;
	logic [1:0]  after_pop;
	logic        pop;

	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[0];
	assign pop        = head_valid && pop_ready;
	assign after_pop  = count_q - {1'b0, pop};
	// room for two new beats even without a pop
	assign space_ok   = (count_q <= 2'd1);

	// shift out the head, then append new beats
	always_comb begin
		entry_n[0] = pop ? entry_q[1] : entry_q[0];
		entry_n[1] = pop ? entry_q[2] : entry_q[1];
		entry_n[2] = entry_q[2];
		for (int i = 0; i < Depth; i++) begin
			if (2'(i) == after_pop && push.cnt != 2'd0) begin
				entry_n[i] = push.r0;
			end else if (2'(i) == after_pop + 2'd1 && push.cnt == 2'd2) begin
				entry_n[i] = push.r1;
			end
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < Depth; i++) begin
			entry_q[i] <= entry_n[i];
		end
	end

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= after_pop + push.cnt;
		end
	end

endmodule

// ----- hw/rtl/utf8_stream_decoder.sv -----
// utf-8 stream decoder top level: byte in, code points out
// results of an accepted byte are registered in the result queue and offered from its head
// throughput: one byte per cycle while cp_ch takes every beat; two-result bytes and output stalls drop ready
// rate is set by the three-entry result queue, which takes a byte only with two slots free
// reset clears the partial code point, the pending count and the result queue
module utf8_stream_decoder
	import u8d_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	u8d_byte_if.sink byte_ch,
	u8d_cp_if.source cp_ch
);

	cp_t     partial_q;
	pend_t   pending_q;
	cp_t     partial_next;
	pend_t   pending_next;
	push_t   dec_push;
	push_t   push;
	logic    accept;
	logic    space_ok;
	logic    head_valid;
	result_t head;

	assign byte_ch.ready = space_ok;
	assign accept        = byte_ch.valid && space_ok;

	u8d_decode u_decode (
		.byte_in      (byte_ch.byte_in),
		.final_byte   (byte_ch.final_byte),
		.partial      (partial_q),
		.pending      (pending_q),
		.partial_next (partial_next),
		.pending_next (pending_next),
		.push         (dec_push)
	);

	// only an accepted beat pushes results
	always_comb begin
		push = dec_push;
		if (!accept) begin
			push.cnt = 2'd0;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= 2'd0;
		end else if (accept) begin
			partial_q <= partial_next;
			pending_q <= pending_next;
		end
	end

	u8d_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop_ready  (cp_ch.ready),
		.head_valid (head_valid),
		.head       (head),
		.space_ok   (space_ok)
	);

	// output beat
	assign cp_ch.valid      = head_valid;
	assign cp_ch.code_point = head.code_point;
	assign cp_ch.replaced   = head.replaced;
	assign cp_ch.run_end    = head.run_end;

endmodule
